>>> hdl/chacha_pkg.sv
// Shared types and constants for the ChaCha20 byte stream cipher.
// Used by the interfaces, controller, datapath and top level; no dependencies.
`default_nettype none

package chacha_pkg;

  localparam int DoubleRounds = 10;
  localparam int KsBytes      = 64;
  localparam int PosW         = 7;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 64;

  localparam logic [31:0] Sigma [4] = '{
    32'h6170_7865, 32'h3320_646E, 32'h7962_2D32, 32'h6B20_6574
  };

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_KEY0     = 3'd1,
    CFG_KEY1     = 3'd2,
    CFG_KEY2     = 3'd3,
    CFG_KEY3     = 3'd4,
    CFG_NONCE_LO = 3'd5,
    CFG_NONCE_HI = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       diag;
    logic [1:0] sub;
    logic       feed;
    logic       emit_direct;
    logic       emit_held;
  } dp_cmd_t;

  typedef struct packed {
    logic enable;
    logic need_block;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/chacha_ifs.sv
// Valid/ready channel interfaces: input bytes, output bytes, register writes.
// Depends on chacha_pkg for the register index and data widths.
`default_nettype none

interface chacha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       chunk_end;
  modport source (output valid, data_in, chunk_end, input ready);
  modport sink   (input valid, data_in, chunk_end, output ready);
endinterface

interface chacha_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       chunk_end_out;
  modport source (output valid, data_out, chunk_end_out, input ready);
  modport sink   (input valid, data_out, chunk_end_out, output ready);
endinterface

interface chacha_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [chacha_pkg::CfgIdxW-1:0]  index;
  logic [chacha_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/chacha_ctrl.sv
// Controller state machine: sequences block generation and byte emission.
// Depends on chacha_pkg for the state enum and command/status structs.
`default_nettype none

module chacha_ctrl #(
  parameter int NumDoubleRounds = chacha_pkg::DoubleRounds
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire chacha_pkg::dp_status_t status_i,
  output chacha_pkg::dp_cmd_t         cmd_o
);

  localparam int NumRounds = 2 * NumDoubleRounds;
  localparam int RndW      = (NumRounds > 1) ? $clog2(NumRounds) : 1;
  localparam logic [RndW-1:0] LastRnd = RndW'(NumRounds - 1);

  chacha_pkg::ctrl_state_e state_q, state_d;
  logic [RndW-1:0]         rnd_q, rnd_d;
  logic [1:0]              sub_q, sub_d;
  logic                    last_step;
  logic                    start_block;

  assign last_step   = (sub_q == 2'd3) && (rnd_q == LastRnd);
  assign start_block = in_valid_i && status_i.out_free && status_i.enable &&
                       status_i.need_block;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      chacha_pkg::ST_IDLE:  if (start_block) state_d = chacha_pkg::ST_ROUND;
      chacha_pkg::ST_ROUND: if (last_step) state_d = chacha_pkg::ST_FEED;
      chacha_pkg::ST_FEED:  state_d = chacha_pkg::ST_EMIT;
      chacha_pkg::ST_EMIT:  if (status_i.out_free) state_d = chacha_pkg::ST_IDLE;
      default:              state_d = chacha_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.diag = rnd_q[0];
    cmd_o.sub  = sub_q;
    in_ready_o = 1'b0;
    case (state_q)
      chacha_pkg::ST_IDLE: begin
        in_ready_o = status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          if (status_i.enable && status_i.need_block) cmd_o.load = 1'b1;
          else cmd_o.emit_direct = 1'b1;
        end
      end
      chacha_pkg::ST_ROUND: cmd_o.step      = 1'b1;
      chacha_pkg::ST_FEED:  cmd_o.feed      = 1'b1;
      chacha_pkg::ST_EMIT:  cmd_o.emit_held = status_i.out_free;
      default:              cmd_o           = '0;
    endcase
  end

  // round / step counters
  always_comb begin
    rnd_d = rnd_q;
    sub_d = sub_q;
    if (state_q == chacha_pkg::ST_ROUND) begin
      sub_d = sub_q + 2'd1;
      if (sub_q == 2'd3) rnd_d = rnd_q + RndW'(1);
    end else if (start_block) begin
      rnd_d = '0;
      sub_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chacha_pkg::ST_IDLE;
      rnd_q   <= '0;
      sub_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      sub_q   <= sub_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/chacha_dp.sv
// Datapath: registers, ChaCha20 state with a shared quarter-round step unit,
// keystream byte select and output register. Depends on chacha_pkg.
`default_nettype none

module chacha_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [chacha_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [chacha_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic [7:0]                        data_in_i,
  input  wire logic                              chunk_end_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [7:0]                             data_out_o,
  output logic                                   chunk_end_out_o,
  input  wire chacha_pkg::dp_cmd_t               cmd_i,
  output chacha_pkg::dp_status_t                 status_o
);

  localparam int PosW = chacha_pkg::PosW;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  logic                enable_q;
  logic [3:0][63:0]    key_q;
  logic [63:0]         nonce_lo_q;
  logic [31:0]         nonce_hi_q;
  logic [31:0]         ctr_q, ctr_d;
  logic [31:0]         live_q, live_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [31:0]         w_q [16];
  logic [31:0]         w_d [16];
  logic [31:0]         w_step [16];
  logic [31:0]         init [16];
  logic [7:0]          hold_data_q;
  logic                hold_end_q;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_data_q;
  logic                out_end_q;
  logic                cfg_restart;
  logic [31:0]         ks_word;
  logic [7:0]          ks_byte;

  assign cfg_restart = cfg_we_i && (cfg_index_i inside {
    chacha_pkg::CFG_KEY0, chacha_pkg::CFG_KEY1, chacha_pkg::CFG_KEY2,
    chacha_pkg::CFG_KEY3, chacha_pkg::CFG_NONCE_LO, chacha_pkg::CFG_NONCE_HI});

  // block input state
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init[i]       = chacha_pkg::Sigma[i];
      init[4 + 2*i] = key_q[i][31:0];
      init[5 + 2*i] = key_q[i][63:32];
    end
    init[12] = ctr_q;
    init[13] = live_q;
    init[14] = nonce_lo_q[63:32];
    init[15] = nonce_hi_q;
  end

  // one add/xor/rotate line of four quarter rounds, column or diagonal
  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] va, vb, vc, vd, sum;
    w_step = w_q;
    for (int j = 0; j < 4; j++) begin
      ia  = {2'd0, 2'(j)};
      ib  = {2'd1, 2'(j) + (cmd_i.diag ? 2'd1 : 2'd0)};
      ic  = {2'd2, 2'(j) + (cmd_i.diag ? 2'd2 : 2'd0)};
      id  = {2'd3, 2'(j) + (cmd_i.diag ? 2'd3 : 2'd0)};
      va  = w_q[ia];
      vb  = w_q[ib];
      vc  = w_q[ic];
      vd  = w_q[id];
      sum = '0;
      case (cmd_i.sub)
        2'd0: begin
          sum = va + vb;
          w_step[ia] = sum;
          w_step[id] = rotl(vd ^ sum, 16);
        end
        2'd1: begin
          sum = vc + vd;
          w_step[ic] = sum;
          w_step[ib] = rotl(vb ^ sum, 12);
        end
        2'd2: begin
          sum = va + vb;
          w_step[ia] = sum;
          w_step[id] = rotl(vd ^ sum, 8);
        end
        default: begin
          sum = vc + vd;
          w_step[ic] = sum;
          w_step[ib] = rotl(vb ^ sum, 7);
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (cmd_i.load)      w_d[i] = init[i];
      else if (cmd_i.step) w_d[i] = w_step[i];
      else if (cmd_i.feed) w_d[i] = w_q[i] + init[i];
      else                 w_d[i] = w_q[i];
    end
  end

  // after feed-forward the state words are the keystream block
  assign ks_word = w_q[pos_q[5:2]];
  assign ks_byte = ks_word[{pos_q[1:0], 3'b000} +: 8];

  always_comb begin
    ctr_d  = ctr_q;
    live_d = live_q;
    pos_d  = pos_q;
    if (cmd_i.feed) begin
      ctr_d = ctr_q + 32'd1;
      if (ctr_q == '1) live_d = live_q + 32'd1;
      pos_d = '0;
    end
    if (cmd_i.emit_held) pos_d = PosW'(1);
    if (cmd_i.emit_direct && enable_q) pos_d = pos_q + PosW'(1);
    if (cfg_restart) begin
      ctr_d  = '0;
      live_d = (cfg_index_i == chacha_pkg::CFG_NONCE_LO) ? cfg_data_i[31:0]
                                                         : nonce_lo_q[31:0];
      pos_d  = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit_direct || cmd_i.emit_held) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      key_q       <= '0;
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      ctr_q       <= '0;
      live_q      <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ctr_q       <= ctr_d;
      live_q      <= live_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (chacha_pkg::cfg_idx_e'(cfg_index_i))
          chacha_pkg::CFG_ENABLE:   enable_q   <= cfg_data_i[0];
          chacha_pkg::CFG_KEY0:     key_q[0]   <= cfg_data_i;
          chacha_pkg::CFG_KEY1:     key_q[1]   <= cfg_data_i;
          chacha_pkg::CFG_KEY2:     key_q[2]   <= cfg_data_i;
          chacha_pkg::CFG_KEY3:     key_q[3]   <= cfg_data_i;
          chacha_pkg::CFG_NONCE_LO: nonce_lo_q <= cfg_data_i;
          chacha_pkg::CFG_NONCE_HI: nonce_hi_q <= cfg_data_i[31:0];
          default:                  ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (cmd_i.load) begin
      hold_data_q <= data_in_i;
      hold_end_q  <= chunk_end_i;
    end
    if (cmd_i.emit_direct) begin
      out_data_q <= enable_q ? (data_in_i ^ ks_byte) : data_in_i;
      out_end_q  <= chunk_end_i;
    end else if (cmd_i.emit_held) begin
      out_data_q <= hold_data_q ^ ks_byte;
      out_end_q  <= hold_end_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_out_o      = out_data_q;
  assign chunk_end_out_o = out_end_q;

  assign status_o.enable     = enable_q;
  assign status_o.need_block = (pos_q == '0) || pos_q[PosW-1];
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

>>> hdl/chacha20_stream_cipher.sv
// Top level of the ChaCha20 byte stream cipher: controller plus datapath.
// Depends on chacha_pkg, the channel interfaces, chacha_ctrl and chacha_dp.
// Usage:
//   in_i   carries one word per byte: data_in and chunk_end.
//   out_o  returns one word per input byte: data_out and chunk_end_out,
//          in order. chunk_end is only echoed.
//   cfg_i  writes registers by index: 0 enable, 1..4 key words, 5 nonce low,
//          6 nonce high; other indexes are dropped. cfg_i.ready is always high.
//          Any key or nonce write restarts the block counter and byte position.
//          Write registers only while no byte is in flight.
// Timing:
//   With enable at 0, or within a keystream block, a byte is taken every cycle
//   while the output is free, and its result shows in the cycle after acceptance.
//   The first byte of each 64-byte block waits for block generation: a load,
//   8*NumDoubleRounds quarter-round steps, a feed-forward and an emit; no byte
//   is taken meanwhile. Block generation is bound by the one shared
//   add/xor/rotate line that works the four quarter rounds of a round in parallel,
//   one line per cycle.
// Reset: config, counter and position clear; the first enabled byte makes a block.
// Stall: hold a waiting result in the output register; take a new byte only while
//   that register is empty or the receiver takes it, otherwise input ready stays low.
`default_nettype none

module chacha20_stream_cipher #(
  parameter int NumDoubleRounds = chacha_pkg::DoubleRounds
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  chacha_cfg_if.sink   cfg_i,
  chacha_in_if.sink    in_i,
  chacha_out_if.source out_o
);

  chacha_pkg::dp_cmd_t    cmd;
  chacha_pkg::dp_status_t status;
  logic                   cfg_we;

  // register port never stalls
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  chacha_ctrl #(
    .NumDoubleRounds(NumDoubleRounds)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  chacha_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .data_in_i       (in_i.data_in),
    .chunk_end_i     (in_i.chunk_end),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .data_out_o      (out_o.data_out),
    .chunk_end_out_o (out_o.chunk_end_out),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

`default_nettype wire

>>> hdl/chacha_checker.sv
// Port-level checks for the ChaCha20 stream cipher, bound to the top level.
// Depends only on the top level's channel signals.
`default_nettype none

module chacha_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] data_out_i,
  input wire logic       chunk_end_out_i
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pending_q, pending_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // bytes taken but not yet returned
  always_comb begin
    pending_d = pending_q + (in_acc ? 2'd1 : 2'd0) - (out_acc ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pending_q <= '0;
    else         pending_q <= pending_d;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_out_i) &&
                                    $stable(chunk_end_out_i))
    else $error("output word changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("output word without a pending input byte");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pending_q == 2'd0 || out_acc)
    else $error("second byte taken while one is still in flight");

  a_in_block_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && pending_q == 2'd0 |=> pending_q == 2'd1 || pending_q == 2'd0)
    else $error("pending count out of range");

endmodule

bind chacha20_stream_cipher chacha_checker u_chacha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .data_out_i      (out_o.data_out),
  .chunk_end_out_i (out_o.chunk_end_out)
);

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the ChaCha20 byte stream cipher: predicts every output word
// with its own keystream generator. Depends on chacha_pkg, chacha_ifs and the RTL.

module testbench;

  // Block generation runs a load, 8 steps per double round, a feed-forward and an emit.
  localparam int BlockCycles = 8 * chacha_pkg::DoubleRounds + 3;
  localparam int HoldCycles  = 200;
  localparam int QuietLimit  = 4000;
  localparam int NumPhases   = 8;
  // Index past the last register; the block must drop the write.
  localparam logic [chacha_pkg::CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  // Keystream predictor and in-order store of expected output words.
  class cipher_scoreboard;
    bit         enable_q;
    bit [63:0]  key_q [4];
    bit [63:0]  nonce_lo_q;
    bit [31:0]  nonce_hi_q;
    bit [31:0]  counter_q;
    bit [31:0]  live_nonce_q;
    bit [7:0]   stream_q [64];
    int unsigned pos_q;
    bit [31:0]  work [16];
    byte_word_t expected_bytes [$];
    int unsigned errors;

    function new();
      enable_q   = 1'b0;
      foreach (key_q[i]) key_q[i] = '0;
      nonce_lo_q = '0;
      nonce_hi_q = '0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      counter_q    = '0;
      live_nonce_q = nonce_lo_q[31:0];
      pos_q        = 0;
    endfunction

    function bit [31:0] rotl32(bit [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void mix(int a, int b, int c, int d);
      work[a] += work[b]; work[d] = rotl32(work[d] ^ work[a], 16);
      work[c] += work[d]; work[b] = rotl32(work[b] ^ work[c], 12);
      work[a] += work[b]; work[d] = rotl32(work[d] ^ work[a], 8);
      work[c] += work[d]; work[b] = rotl32(work[b] ^ work[c], 7);
    endfunction

    function void generate_block();
      bit [31:0] init [16];
      bit [31:0] sum;
      for (int i = 0; i < 4; i++) begin
        init[i] = chacha_pkg::Sigma[i];
        init[4 + 2 * i] = key_q[i][31:0];
        init[5 + 2 * i] = key_q[i][63:32];
      end
      init[12] = counter_q;
      init[13] = live_nonce_q;
      init[14] = nonce_lo_q[63:32];
      init[15] = nonce_hi_q;
      work = init;
      for (int r = 0; r < chacha_pkg::DoubleRounds; r++) begin
        mix(0, 4, 8, 12); mix(1, 5, 9, 13); mix(2, 6, 10, 14); mix(3, 7, 11, 15);
        mix(0, 5, 10, 15); mix(1, 6, 11, 12); mix(2, 7, 8, 13); mix(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
        sum = work[i] + init[i];
        for (int b = 0; b < 4; b++) stream_q[i * 4 + b] = sum[b * 8 +: 8];
      end
      counter_q++;
      if (counter_q == 0) live_nonce_q++;
      pos_q = 0;
    endfunction

    function void write_reg(logic [chacha_pkg::CfgIdxW-1:0] idx, bit [63:0] value);
      case (idx)
        chacha_pkg::CFG_ENABLE: begin
          enable_q = value[0];
          return;
        end
        chacha_pkg::CFG_KEY0:     key_q[0]   = value;
        chacha_pkg::CFG_KEY1:     key_q[1]   = value;
        chacha_pkg::CFG_KEY2:     key_q[2]   = value;
        chacha_pkg::CFG_KEY3:     key_q[3]   = value;
        chacha_pkg::CFG_NONCE_LO: nonce_lo_q = value;
        chacha_pkg::CFG_NONCE_HI: nonce_hi_q = value[31:0];
        default: return;
      endcase
      restart();
    endfunction

    function void take_plain_byte(logic [7:0] data, logic last);
      byte_word_t w;
      w.data = data;
      w.last = last;
      if (enable_q) begin
        if (pos_q == 0 || pos_q >= 64) generate_block();
        w.data ^= stream_q[pos_q % 64];
        pos_q++;
      end
      expected_bytes.push_back(w);
    endfunction

    task report_mismatch(string what);
      $display("%0t ns  MISMATCH  %s", $realtime, what);
      errors++;
    endtask

    task check_cipher_byte(logic [7:0] data, logic last);
      byte_word_t w;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected word data_out=%02h", data));
        return;
      end
      w = expected_bytes.pop_front();
      if (data !== w.data)
        report_mismatch($sformatf("data_out %02h, expected %02h", data, w.data));
      if (last !== w.last)
        report_mismatch($sformatf("chunk_end_out %b, expected %b", last, w.last));
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  chacha_cfg_if cfg_bus ();
  chacha_in_if  in_bus ();
  chacha_out_if out_bus ();

  chacha20_stream_cipher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  cipher_scoreboard sb = new();

  // Shared knobs between the stimulus and the receiver.
  bit idle_on;
  bit hold_output;
  int unsigned quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Random 64-bit value, biased toward the all-zero and all-one extremes.
  function automatic bit [63:0] pick64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Write one register; the word moves on the first edge with ready high.
  task automatic write_reg(logic [chacha_pkg::CfgIdxW-1:0] idx, bit [63:0] value);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  // Offer one byte, with an optional idle burst ahead of it. Return at the
  // falling edge after the word is taken, valid still high.
  task automatic send_byte(logic [7:0] data, logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_bus.valid     = 1'b1;
    in_bus.data_in   = data;
    in_bus.chunk_end = last;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.take_plain_byte(data, last);
    @(negedge clk_i);
  endtask

  // Drop valid, wait out every expected word, then let a block generation
  // that may still run inside the block settle before any register write.
  task automatic wait_idle();
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (BlockCycles + 8) @(negedge clk_i);
  endtask

  // Receiver: random back-pressure bursts, plus one long hold on request.
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        out_bus.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_output   = 1'b0;
        out_bus.ready = 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_bus.ready = 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  // Check every output word as it is taken.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready)
        sb.check_cipher_byte(out_bus.data_out, out_bus.chunk_end_out);
    end
  end

  // Watchdog: end the run if no word moves on any channel for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence: directed words first, then random phases of register
  // settings and byte streams.
  initial begin
    int unsigned count;
    in_bus.valid     = 1'b0;
    in_bus.data_in   = '0;
    in_bus.chunk_end = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = chacha_pkg::CFG_ENABLE;
    cfg_bus.data     = '0;
    idle_on          = 1'b0;
    hold_output      = 1'b0;
    rst_ni           = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Out of reset the cipher is off: bytes pass through, flag echoed.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    wait_idle();

    // Counting key 00..1f with a sample nonce; the unused index is dropped.
    write_reg(chacha_pkg::CFG_KEY0, 64'h0706_0504_0302_0100);
    write_reg(chacha_pkg::CFG_KEY1, 64'h0F0E_0D0C_0B0A_0908);
    write_reg(chacha_pkg::CFG_KEY2, 64'h1716_1514_1312_1110);
    write_reg(chacha_pkg::CFG_KEY3, 64'h1F1E_1D1C_1B1A_1918);
    write_reg(chacha_pkg::CFG_NONCE_LO, 64'h4A00_0000_0900_0000);
    write_reg(chacha_pkg::CFG_NONCE_HI, 64'h0);
    write_reg(chacha_pkg::CFG_ENABLE, 64'h1);
    write_reg(CfgUnused, 64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    wait_idle();

    // Turn the cipher off mid-block, then back on: position must hold.
    write_reg(chacha_pkg::CFG_ENABLE, 64'h0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
    wait_idle();
    write_reg(chacha_pkg::CFG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
    send_byte(8'h3C, 1'b0);
    wait_idle();
    write_reg(chacha_pkg::CFG_ENABLE, 64'h1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // All-ones key and nonce, written mid-block: restart from a fresh block.
    write_reg(chacha_pkg::CFG_KEY0, '1);
    write_reg(chacha_pkg::CFG_KEY1, '1);
    write_reg(chacha_pkg::CFG_KEY2, '1);
    write_reg(chacha_pkg::CFG_KEY3, '1);
    write_reg(chacha_pkg::CFG_NONCE_LO, '1);
    write_reg(chacha_pkg::CFG_NONCE_HI, '1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    wait_idle();

    // Random phases of 40 to 90 bytes each. Most run with the cipher on; one holds the
    // receiver off; the last has no idling.
    for (int phase = 0; phase < NumPhases; phase++) begin
      idle_on = (phase != NumPhases - 1);
      if (phase == 0 || $urandom_range(0, 2) == 0)
        write_reg(chacha_pkg::CFG_KEY0, pick64());
      if (phase == 0 || $urandom_range(0, 2) == 0)
        write_reg(chacha_pkg::CFG_KEY1, pick64());
      if (phase == 0 || $urandom_range(0, 2) == 0)
        write_reg(chacha_pkg::CFG_KEY2, pick64());
      if (phase == 0 || $urandom_range(0, 2) == 0)
        write_reg(chacha_pkg::CFG_KEY3, pick64());
      if (phase == 0 || $urandom_range(0, 2) == 0)
        write_reg(chacha_pkg::CFG_NONCE_LO, pick64());
      if (phase == 0 || $urandom_range(0, 2) == 0)
        write_reg(chacha_pkg::CFG_NONCE_HI, pick64());
      if ($urandom_range(0, 5) == 0) write_reg(CfgUnused, pick64());
      write_reg(chacha_pkg::CFG_ENABLE,
                {$urandom, $urandom_range(0, 7) != 0 ? 32'h1 : 32'h0});
      if (phase == 3) hold_output = 1'b1;
      count = $urandom_range(40, 90);
      for (int n = 0; n < count; n++)
        send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
